FILE: design/rmq_pkg.sv
// Shared widths, types and codes for the rotation matrix to quaternion core.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int CW        = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int MW        = CW - 1;
    localparam int SW        = 2 * MW + 2;
    localparam int NS        = SW / 2;
    localparam int QW        = FRAC_BITS + 1;
    localparam int DW        = MW + FRAC_BITS + 1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic [MW-1:0] mag_t;

    typedef struct packed {
        logic            deg;
        logic [3:0]      neg;
        logic [3:0][MW-1:0] mag;
        logic [SW-1:0]   v;
        logic [SW-1:0]   r;
    } sqrt_t;

    typedef struct packed {
        logic            deg;
        logic [3:0]      neg;
        logic [NS-1:0]   n;
        logic [3:0][DW-1:0] rem;
        logic [3:0][QW-1:0] q;
    } div_t;
endpackage
`default_nettype wire

FILE: design/rmq_sqrt_cell.sv
// One bit step of the pipelined integer square root.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell
    import rmq_pkg::*;
#(
    parameter int POS = 0
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire sqrt_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output sqrt_t      out_data
);
    logic          valid_reg;
    sqrt_t         data_reg;
    sqrt_t         data_next;
    logic [SW-1:0] b;
    logic [SW:0]   t;

    always_comb begin
        b = SW'(1) << (2 * POS);
        t = {1'b0, in_data.r} + {1'b0, b};
        data_next = in_data;
        if ({1'b0, in_data.v} >= t) begin
            data_next.v = in_data.v - t[SW-1:0];
            data_next.r = (in_data.r >> 1) + b;
        end else begin
            data_next.r = in_data.r >> 1;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

FILE: design/rmq_div_cell.sv
// One quotient bit of the four-lane restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell
    import rmq_pkg::*;
#(
    parameter int K = 0
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire div_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output div_t      out_data
);
    logic          valid_reg;
    div_t          data_reg;
    div_t          data_next;
    logic [DW:0]   dv;

    always_comb begin
        dv = (DW + 1)'(in_data.n) << K;
        data_next = in_data;
        for (int l = 0; l < 4; l++) begin
            if ({1'b0, in_data.rem[l]} >= dv) begin
                data_next.rem[l] = in_data.rem[l] - dv[DW-1:0];
                data_next.q[l][K] = 1'b1;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

FILE: design/rotation_matrix_to_quaternion_core.sv
// Pipeline from input beat to result beat: 3 setup stages, 19 square root cells,
// 15 divider cells, 1 output register.
// Throughput: one matrix per cycle; every stage holds its beat and advances
// whenever the stage after it is empty or moving.
// Reset: synchronous active-low aresetn clears all stage valid flags; the
// pipeline is empty and ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [IN_W-1:0]  s_m11,
    input  wire logic signed [IN_W-1:0]  s_m12,
    input  wire logic signed [IN_W-1:0]  s_m13,
    input  wire logic signed [IN_W-1:0]  s_m21,
    input  wire logic signed [IN_W-1:0]  s_m22,
    input  wire logic signed [IN_W-1:0]  s_m23,
    input  wire logic signed [IN_W-1:0]  s_m31,
    input  wire logic signed [IN_W-1:0]  s_m32,
    input  wire logic signed [IN_W-1:0]  s_m33,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [OUT_W-1:0]      m_qx,
    output logic signed [OUT_W-1:0]      m_qy,
    output logic signed [OUT_W-1:0]      m_qz,
    output logic signed [OUT_W-1:0]      m_qw,
    output logic                         m_degenerate
);
    localparam comp_t ONE = comp_t'(1) <<< FRAC_BITS;

    comp_t a11, a12, a13, a21, a22, a23, a31, a32, a33;
    comp_t tr, arg;
    logic [1:0] axis;
    comp_t [3:0] c_next;

    // stage 0: unnormalized quaternion
    logic        st0_valid_reg;
    logic        st0_ready;
    comp_t [3:0] st0_c_reg;
    logic        st0_deg_reg;

    // stage 1: magnitudes and squares
    logic                     st1_valid_reg;
    logic                     st1_ready;
    logic [3:0]               st1_neg_reg;
    logic [3:0][MW-1:0]       st1_mag_reg;
    logic [3:0][2*MW-1:0]     st1_sq_reg;
    logic                     st1_deg_reg;

    logic  st2_ready;
    sqrt_t st2_next;

    logic        sq_valid [0:NS];
    logic        sq_ready [0:NS];
    sqrt_t       sq_data  [0:NS];

    logic        dv_valid [0:QW];
    logic        dv_ready [0:QW];
    div_t        dv_data  [0:QW];

    logic                   out_valid_reg;
    logic signed [OUT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic                   deg_reg;
    logic [3:0][OUT_W-1:0]  q_next;
    logic                   deg_next;
    logic [31:0]            qe;

    always_comb begin
        a11 = comp_t'(s_m11); a12 = comp_t'(s_m12); a13 = comp_t'(s_m13);
        a21 = comp_t'(s_m21); a22 = comp_t'(s_m22); a23 = comp_t'(s_m23);
        a31 = comp_t'(s_m31); a32 = comp_t'(s_m32); a33 = comp_t'(s_m33);
        tr = a11 + a22 + a33;
        axis = AXIS_X;
        if (a22 > a11) axis = AXIS_Y;
        if ((axis == AXIS_X && a33 > a11) || (axis == AXIS_Y && a33 > a22)) axis = AXIS_Z;
        if (tr > 0) begin
            arg = tr + ONE;
            c_next[0] = a32 - a23;
            c_next[1] = a13 - a31;
            c_next[2] = a21 - a12;
            c_next[3] = arg;
        end else begin
            unique case (axis)
                AXIS_Y: begin
                    arg = a22 - a33 - a11 + ONE;
                    c_next[1] = arg;
                    c_next[2] = a32 + a23;
                    c_next[0] = a12 + a21;
                    c_next[3] = a13 - a31;
                end
                AXIS_Z: begin
                    arg = a33 - a11 - a22 + ONE;
                    c_next[2] = arg;
                    c_next[0] = a13 + a31;
                    c_next[1] = a23 + a32;
                    c_next[3] = a21 - a12;
                end
                default: begin
                    arg = a11 - a22 - a33 + ONE;
                    c_next[0] = arg;
                    c_next[1] = a21 + a12;
                    c_next[2] = a31 + a13;
                    c_next[3] = a32 - a23;
                end
            endcase
        end
    end

    assign st0_ready = !st0_valid_reg || st1_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_ready   = st0_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (st0_ready) st0_valid_reg <= s_valid;
            if (st1_ready) st1_valid_reg <= st0_valid_reg;
        end
        if (st0_ready && s_valid) begin
            st0_c_reg   <= c_next;
            st0_deg_reg <= (arg <= 0);
        end
        if (st1_ready && st0_valid_reg) begin
            st1_deg_reg <= st0_deg_reg;
            for (int l = 0; l < 4; l++) begin
                st1_neg_reg[l] <= st0_c_reg[l][CW-1];
                st1_mag_reg[l] <= st0_c_reg[l][CW-1] ? MW'(-st0_c_reg[l])
                                                     : MW'(st0_c_reg[l]);
                st1_sq_reg[l]  <= (2*MW)'(
                    (st0_c_reg[l][CW-1] ? MW'(-st0_c_reg[l]) : MW'(st0_c_reg[l])) *
                    (st0_c_reg[l][CW-1] ? MW'(-st0_c_reg[l]) : MW'(st0_c_reg[l])));
            end
        end
    end

    // stage 2: sum of squares, start of the root chain
    always_comb begin
        st2_next.deg = st1_deg_reg;
        st2_next.neg = st1_neg_reg;
        st2_next.mag = st1_mag_reg;
        st2_next.v   = SW'(st1_sq_reg[0]) + SW'(st1_sq_reg[1])
                     + SW'(st1_sq_reg[2]) + SW'(st1_sq_reg[3]);
        st2_next.r   = '0;
    end

    assign st2_ready = !sq_valid[0] || sq_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid[0] <= 1'b0;
        end else if (st2_ready) begin
            sq_valid[0] <= st1_valid_reg;
        end
        if (st2_ready && st1_valid_reg) begin
            sq_data[0] <= st2_next;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        rmq_sqrt_cell #(.POS(NS - 1 - g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[g]),
            .in_ready  (sq_ready[g]),
            .in_data   (sq_data[g]),
            .out_valid (sq_valid[g+1]),
            .out_ready (sq_ready[g+1]),
            .out_data  (sq_data[g+1])
        );
    end

    always_comb begin
        dv_data[0].deg = sq_data[NS].deg || (sq_data[NS].r[NS-1:0] == '0);
        dv_data[0].neg = sq_data[NS].neg;
        dv_data[0].n   = sq_data[NS].r[NS-1:0];
        dv_data[0].q   = '0;
        for (int l = 0; l < 4; l++) begin
            dv_data[0].rem[l] = (DW'(sq_data[NS].mag[l]) << FRAC_BITS)
                              + DW'(sq_data[NS].r[NS-1:1]);
        end
    end
    assign dv_valid[0]  = sq_valid[NS];
    assign sq_ready[NS] = dv_ready[0];

    for (genvar g = 0; g < QW; g++) begin : g_div
        rmq_div_cell #(.K(QW - 1 - g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[g]),
            .in_ready  (dv_ready[g]),
            .in_data   (dv_data[g]),
            .out_valid (dv_valid[g+1]),
            .out_ready (dv_ready[g+1]),
            .out_data  (dv_data[g+1])
        );
    end

    // output register: sign, saturation, degenerate
    always_comb begin
        deg_next = dv_data[QW].deg;
        qe = '0;
        for (int l = 0; l < 4; l++) begin
            qe = 32'(dv_data[QW].q[l]);
            if (deg_next) begin
                q_next[l] = '0;
            end else if (dv_data[QW].neg[l]) begin
                q_next[l] = (qe > 32'd32768) ? 16'h8000 : OUT_W'(-qe);
            end else begin
                q_next[l] = (qe > 32'd32767) ? 16'h7fff : OUT_W'(qe);
            end
        end
    end

    assign dv_ready[QW] = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dv_ready[QW]) begin
            out_valid_reg <= dv_valid[QW];
        end
        if (dv_ready[QW] && dv_valid[QW]) begin
            qx_reg  <= q_next[0];
            qy_reg  <= q_next[1];
            qz_reg  <= q_next[2];
            qw_reg  <= q_next[3];
            deg_reg <= deg_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_qx         = qx_reg;
    assign m_qy         = qy_reg;
    assign m_qz         = qz_reg;
    assign m_qw         = qw_reg;
    assign m_degenerate = deg_reg;
endmodule
`default_nettype wire

FILE: dv/rotation_matrix_to_quaternion_core_test.sv
// Self-checking bench for the matrix to quaternion core: random and directed matrices.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core_test;
    import rmq_pkg::*;

    typedef logic signed [IN_W-1:0] elem_t;
    typedef struct packed {
        logic signed [OUT_W-1:0] qx, qy, qz, qw;
        logic deg;
    } quat_t;

    class quat_scoreboard;
        quat_t pending[$];
        int errors;
        int beats_in;
        int beats_out;
        int degen_seen;

        function automatic longint unsigned root64(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic logic [OUT_W-1:0] scale(longint c, longint unsigned n);
            longint unsigned mg, q;
            mg = (c < 0) ? longint'(-c) : longint'(c);
            q = (mg * (64'd1 << FRAC_BITS) + (n >> 1)) / n;
            if (c < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
            return (q > 32767) ? 16'h7fff : 16'(q);
        endfunction

        function void note_matrix(elem_t e[9]);
            longint m[3][3];
            longint q[4];
            longint tr, arg, one;
            longint unsigned s, n;
            int i, j, k;
            quat_t r;
            one = longint'(1) << FRAC_BITS;
            for (int a = 0; a < 9; a++) m[a/3][a%3] = e[a];
            tr = m[0][0] + m[1][1] + m[2][2];
            if (tr > 0) begin
                arg = tr + one;
                q[0] = m[2][1] - m[1][2];
                q[1] = m[0][2] - m[2][0];
                q[2] = m[1][0] - m[0][1];
                q[3] = arg;
            end else begin
                i = 0;
                if (m[1][1] > m[0][0]) i = 1;
                if (m[2][2] > m[i][i]) i = 2;
                j = (i + 1) % 3;
                k = (j + 1) % 3;
                arg = m[i][i] - m[j][j] - m[k][k] + one;
                q[i] = arg;
                q[j] = m[j][i] + m[i][j];
                q[k] = m[k][i] + m[i][k];
                q[3] = m[k][j] - m[j][k];
            end
            r = '0;
            s = 0;
            for (int t = 0; t < 4; t++) s += longint'(q[t] * q[t]);
            n = root64(s);
            if (arg <= 0 || n == 0) begin
                r.deg = 1'b1;
            end else begin
                r.qx = scale(q[0], n);
                r.qy = scale(q[1], n);
                r.qz = scale(q[2], n);
                r.qw = scale(q[3], n);
            end
            pending.push_back(r);
            beats_in++;
        endfunction

        function void check_quat(quat_t got);
            quat_t x;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            x = pending.pop_front();
            beats_out++;
            if (x.deg) degen_seen++;
            if (got.qx !== x.qx) begin
                $error("qx expected %0d actual %0d", x.qx, got.qx); errors++;
            end
            if (got.qy !== x.qy) begin
                $error("qy expected %0d actual %0d", x.qy, got.qy); errors++;
            end
            if (got.qz !== x.qz) begin
                $error("qz expected %0d actual %0d", x.qz, got.qz); errors++;
            end
            if (got.qw !== x.qw) begin
                $error("qw expected %0d actual %0d", x.qw, got.qw); errors++;
            end
            if (got.deg !== x.deg) begin
                $error("degenerate expected %0d actual %0d", x.deg, got.deg); errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    elem_t s_m11 = 0, s_m12 = 0, s_m13 = 0, s_m21 = 0, s_m22 = 0;
    elem_t s_m23 = 0, s_m31 = 0, s_m32 = 0, s_m33 = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [OUT_W-1:0] m_qx, m_qy, m_qz, m_qw;
    logic m_degenerate;
    quat_scoreboard sb;
    int cycles = 0;
    localparam int LIMIT = 400000;

    always #4 aclk = ~aclk;

    rotation_matrix_to_quaternion_core uut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_quat('{m_qx, m_qy, m_qz, m_qw, m_degenerate});
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        int ph;
        ph = cycles % 300;
        if (ph < 60) m_ready <= 1'b1;
        else if (ph < 150) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 2) == 0);
    end

    task automatic send_matrix(elem_t e[9]);
        s_m11 <= e[0]; s_m12 <= e[1]; s_m13 <= e[2];
        s_m21 <= e[3]; s_m22 <= e[4]; s_m23 <= e[5];
        s_m31 <= e[6]; s_m32 <= e[7]; s_m33 <= e[8];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_matrix(e);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic elem_t rand_elem(int mode);
        case (mode)
            0: return elem_t'($urandom());
            1: return elem_t'($urandom_range(0, 32767) - 16384);
            default: return elem_t'($urandom_range(0, 600) - 300);
        endcase
    endfunction

    task automatic random_matrix();
        elem_t e[9];
        int mode, sel;
        real a, c, s;
        mode = $urandom_range(0, 3);
        if (mode == 3) begin
            // near-rotation about one axis
            a = $urandom_range(0, 6283) / 1000.0;
            c = $cos(a) * 16384.0;
            s = $sin(a) * 16384.0;
            sel = $urandom_range(0, 2);
            foreach (e[t]) e[t] = rand_elem(2);
            e[sel*4] = 16384;
            e[((sel+1)%3)*4] = elem_t'($rtoi(c));
            e[((sel+2)%3)*4] = elem_t'($rtoi(c));
            e[((sel+1)%3)*3 + (sel+2)%3] = elem_t'(-$rtoi(s));
            e[((sel+2)%3)*3 + (sel+1)%3] = elem_t'($rtoi(s));
        end else begin
            foreach (e[t]) e[t] = rand_elem(mode);
        end
        send_matrix(e);
    endtask

    initial begin
        elem_t e[9];
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // identity, 180 degrees about each axis, ties, extremes, zero
        e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(e);
        e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(e);
        e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(e);
        e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
        e = '{-8192, 5, 7, 3, -8192, 1, 2, 9, -8192}; send_matrix(e);
        e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(e);
        e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(e);
        e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(e);
        e = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        send_matrix(e);
        e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_matrix(e);
        e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_matrix(e);
        e = '{1, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
        e = '{0, 100, -100, 200, -16384, 50, 0, 0, 0}; send_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, -16385}; send_matrix(e);
        e = '{11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384}; send_matrix(e);
        for (int b = 0; b < 150; b++) begin
            int len;
            len = (b % 10 == 0) ? 40 : $urandom_range(1, 16);
            repeat (len) random_matrix();
            idle_cycles($urandom_range(0, 6));
        end
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Covered %0d matrices, %0d results, %0d degenerate.",
                 sb.beats_in, sb.beats_out, sb.degen_seen);
        $display("Directed axis, tie and extreme cases plus random bursts with stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: sim.f
design/rmq_pkg.sv
design/rmq_sqrt_cell.sv
design/rmq_div_cell.sv
design/rotation_matrix_to_quaternion_core.sv
dv/rotation_matrix_to_quaternion_core_test.sv
